FILE: hdl/ckcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ckcb_pkg;

	// Default limits for the top-level parameters
	localparam int unsigned CKCB_MAX_RECT_SIDE    = 256;
	localparam int unsigned CKCB_MAX_DISPLAY_SIDE = 2048;

	// Fixed field widths
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned RSIDE_W   = 9;
	localparam int unsigned DSIDE_W   = 12;
	localparam int unsigned PIXEL_W   = 32;
	localparam int unsigned ADDR_W    = 22;
	localparam int unsigned REG_IDX_W = 3;

	// Register reset values
	localparam logic [COORD_W-1:0] DEST_X_RST         = '0;
	localparam logic [COORD_W-1:0] DEST_Y_RST         = '0;
	localparam logic [RSIDE_W-1:0] RECT_WIDTH_RST     = 9'd32;
	localparam logic [RSIDE_W-1:0] RECT_HEIGHT_RST    = 9'd32;
	localparam logic [DSIDE_W-1:0] DISPLAY_WIDTH_RST  = 12'd1280;
	localparam logic [DSIDE_W-1:0] DISPLAY_HEIGHT_RST = 12'd720;
	localparam logic [PIXEL_W-1:0] COLOR_KEY_RST      = 32'h00FF00FF;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEST_X,
		REG_DEST_Y,
		REG_RECT_WIDTH,
		REG_RECT_HEIGHT,
		REG_DISPLAY_WIDTH,
		REG_DISPLAY_HEIGHT,
		REG_COLOR_KEY
	} ckcb_reg_t;

	// Per-pixel status carried from the raster stage to the write stage
	typedef struct packed {
		logic visible;
		logic done;
	} ckcb_stat_t;

	// Rectangle side: zero acts as one, oversize saturates at the limit
	function automatic logic [RSIDE_W-1:0] rect_side(input logic [RSIDE_W-1:0] v,
		input int unsigned lim);
		logic [RSIDE_W-1:0] r;
		if (v == '0) begin
			r = RSIDE_W'(1);
		end else if (32'(v) > lim) begin
			r = RSIDE_W'(lim);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Display side: oversize saturates at the limit
	function automatic logic [DSIDE_W-1:0] disp_side(input logic [DSIDE_W-1:0] v,
		input int unsigned lim);
		logic [DSIDE_W-1:0] r;
		if (32'(v) > lim) begin
			r = DSIDE_W'(lim);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ckcb_raster.sv
`timescale 1ns / 1ps
`default_nettype none

module ckcb_raster import ckcb_pkg::*; #(
	parameter int unsigned MAX_RECT_SIDE    = CKCB_MAX_RECT_SIDE,
	parameter int unsigned MAX_DISPLAY_SIDE = CKCB_MAX_DISPLAY_SIDE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [PIXEL_W-1:0]        src_pixel,
	input  logic signed [COORD_W-1:0] dest_x,
	input  logic signed [COORD_W-1:0] dest_y,
	input  logic [RSIDE_W-1:0]        rect_width,
	input  logic [RSIDE_W-1:0]        rect_height,
	input  logic [DSIDE_W-1:0]        display_width,
	input  logic [DSIDE_W-1:0]        display_height,
	output logic [PIXEL_W-1:0]        pixel_s1,
	output logic [((MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE))-1:0] px_s1,
	output logic [((MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE))-1:0] py_s1,
	output ckcb_stat_t                stat_s1
);

	localparam int unsigned CW  = (MAX_RECT_SIDE > 1) ? $clog2(MAX_RECT_SIDE) : 1;
	localparam int unsigned XW  = (MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE);
	localparam int unsigned RW  = ((CW > RSIDE_W) ? CW : RSIDE_W) + 1;
	localparam int unsigned PXW = ((COORD_W > CW + 1) ? COORD_W : CW + 1) + 1;

	logic [CW-1:0]  col_q, row_q;
	logic [RSIDE_W-1:0] w, h;
	logic [DSIDE_W-1:0] dw, dh;
	logic last_col, last_row;
	logic signed [PXW-1:0] px, py;
	logic vis_x, vis_y;

	assign w  = rect_side(rect_width, MAX_RECT_SIDE);
	assign h  = rect_side(rect_height, MAX_RECT_SIDE);
	assign dw = disp_side(display_width, MAX_DISPLAY_SIDE);
	assign dh = disp_side(display_height, MAX_DISPLAY_SIDE);

	// A counter at or past the last position counts as on it
	assign last_col = (RW'(col_q) + RW'(1)) >= RW'(w);
	assign last_row = (RW'(row_q) + RW'(1)) >= RW'(h);

	assign px = PXW'(dest_x) + $signed(PXW'(col_q));
	assign py = PXW'(dest_y) + $signed(PXW'(row_q));

	assign vis_x = !px[PXW-1] && (px[PXW-2:0] < (PXW-1)'(dw));
	assign vis_y = !py[PXW-1] && (py[PXW-2:0] < (PXW-1)'(dh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_s1        <= src_pixel;
			px_s1           <= px[XW-1:0];
			py_s1           <= py[XW-1:0];
			stat_s1.visible <= vis_x && vis_y;
			stat_s1.done    <= last_col && last_row;
		end
	end

	a_wrap_rect: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_col && last_row |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after the last pixel");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_col |=> col_q == $past(col_q) + CW'(1) && row_q == $past(row_q))
		else $error("column counter did not step");

endmodule

`default_nettype wire

FILE: hdl/ckcb_write.sv
`timescale 1ns / 1ps
`default_nettype none

module ckcb_write import ckcb_pkg::*; #(
	parameter int unsigned MAX_DISPLAY_SIDE = CKCB_MAX_DISPLAY_SIDE
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [PIXEL_W-1:0]  pixel_s1,
	input  logic [((MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE))-1:0] px_s1,
	input  logic [((MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE))-1:0] py_s1,
	input  ckcb_stat_t          stat_s1,
	input  logic [DSIDE_W-1:0]  display_width,
	input  logic [PIXEL_W-1:0]  color_key,
	output logic                write_enable_s2,
	output logic [ADDR_W-1:0]   write_address_s2,
	output logic [PIXEL_W-1:0]  write_pixel_s2,
	output logic                rect_done_s2
);

	localparam int unsigned XW = (MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE);
	localparam int unsigned PW = XW + DSIDE_W;
	localparam int unsigned SW = (PW + 1 > ADDR_W) ? PW + 1 : ADDR_W;

	logic [DSIDE_W-1:0] dw;
	logic [PW-1:0] prod;
	logic [SW-1:0] sum;
	logic we;

	assign dw   = disp_side(display_width, MAX_DISPLAY_SIDE);
	assign prod = PW'(py_s1) * PW'(dw);
	assign sum  = SW'(prod) + SW'(px_s1);
	assign we   = stat_s1.visible && (pixel_s1 != color_key);

	always_ff @(posedge clk) begin
		if (advance) begin
			write_enable_s2  <= we;
			write_address_s2 <= we ? sum[ADDR_W-1:0] : '0;
			write_pixel_s2   <= we ? pixel_s1 : '0;
			rect_done_s2     <= stat_s1.done;
		end
	end

	a_clip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !stat_s1.visible |=>
			!write_enable_s2 && write_address_s2 == '0 && write_pixel_s2 == '0)
		else $error("clipped pixel produced a write");

endmodule

`default_nettype wire

FILE: hdl/color_keyed_clipped_blit.sv
`timescale 1ns / 1ps
`default_nettype none

// Color-keyed, clipped sprite blit.
//
// Feed the source pixels of a rectangle on src_pixel (in_valid/in_ready),
// left to right, then top to bottom. Each request yields exactly one result
// on the out channel (out_valid/out_ready): write_enable is high when the
// destination position (dest_x + column, dest_y + row) lies inside the
// display and the pixel differs from color_key; write_address is then
// (dest_y + row) * display_width + dest_x + column. rect_done flags the last
// pixel of the rectangle, after which the column and row counters wrap to zero.
// Pipeline: two register stages, the raster stage and then the write stage.
// Throughput: one pixel per clock while the receiver does not stall; the
// write stage holds the single 12 x 11 bit address multiply.
// Program registers through cfg_write/cfg_index/cfg_data only while the
// pipeline is empty. Reset clears the counters and loads the register
// defaults (32 x 32 rectangle at the origin, 1280 x 720 display, key
// 0x00FF00FF). When the receiver stalls, the result holds, the raster
// stage fills, and in_ready drops once both stages are full.

module color_keyed_clipped_blit import ckcb_pkg::*; #(
	parameter int unsigned MAX_RECT_SIDE    = CKCB_MAX_RECT_SIDE,
	parameter int unsigned MAX_DISPLAY_SIDE = CKCB_MAX_DISPLAY_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PIXEL_W-1:0]   cfg_data,
	// source pixels
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIXEL_W-1:0]   src_pixel,
	// frame-buffer writes
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 write_enable,
	output logic [ADDR_W-1:0]    write_address,
	output logic [PIXEL_W-1:0]   write_pixel,
	output logic                 rect_done
);

	localparam int unsigned XW = (MAX_DISPLAY_SIDE > 4096) ? 12 : $clog2(MAX_DISPLAY_SIDE);

	// Configuration registers
	logic signed [COORD_W-1:0] dest_x_q, dest_y_q;
	logic [RSIDE_W-1:0] rect_width_q, rect_height_q;
	logic [DSIDE_W-1:0] display_width_q, display_height_q;
	logic [PIXEL_W-1:0] color_key_q;

	// Pipeline control
	logic valid_s1, valid_s2;
	logic s1_ready, s2_ready;
	logic adv1, adv2;

	// Stage 1 payload
	logic [PIXEL_W-1:0] pixel_s1;
	logic [XW-1:0]      px_s1, py_s1;
	ckcb_stat_t         stat_s1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q         <= DEST_X_RST;
			dest_y_q         <= DEST_Y_RST;
			rect_width_q     <= RECT_WIDTH_RST;
			rect_height_q    <= RECT_HEIGHT_RST;
			display_width_q  <= DISPLAY_WIDTH_RST;
			display_height_q <= DISPLAY_HEIGHT_RST;
			color_key_q      <= COLOR_KEY_RST;
		end else if (cfg_write) begin
			unique case (ckcb_reg_t'(cfg_index))
				REG_DEST_X:         dest_x_q         <= cfg_data[COORD_W-1:0];
				REG_DEST_Y:         dest_y_q         <= cfg_data[COORD_W-1:0];
				REG_RECT_WIDTH:     rect_width_q     <= cfg_data[RSIDE_W-1:0];
				REG_RECT_HEIGHT:    rect_height_q    <= cfg_data[RSIDE_W-1:0];
				REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data[DSIDE_W-1:0];
				REG_DISPLAY_HEIGHT: display_height_q <= cfg_data[DSIDE_W-1:0];
				REG_COLOR_KEY:      color_key_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage takes a new request whenever it is empty or its content moves on
	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_ready = s1_ready;
	assign adv1     = in_valid && s1_ready;
	assign adv2     = valid_s1 && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: raster counters, destination position and clip test
	ckcb_raster #(
		.MAX_RECT_SIDE    (MAX_RECT_SIDE),
		.MAX_DISPLAY_SIDE (MAX_DISPLAY_SIDE)
	) u_raster (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (adv1),
		.src_pixel      (src_pixel),
		.dest_x         (dest_x_q),
		.dest_y         (dest_y_q),
		.rect_width     (rect_width_q),
		.rect_height    (rect_height_q),
		.display_width  (display_width_q),
		.display_height (display_height_q),
		.pixel_s1       (pixel_s1),
		.px_s1          (px_s1),
		.py_s1          (py_s1),
		.stat_s1        (stat_s1)
	);

	// Stage 2: color key, linear address and the result register
	ckcb_write #(
		.MAX_DISPLAY_SIDE (MAX_DISPLAY_SIDE)
	) u_write (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (adv2),
		.pixel_s1         (pixel_s1),
		.px_s1            (px_s1),
		.py_s1            (py_s1),
		.stat_s1          (stat_s1),
		.display_width    (display_width_q),
		.color_key        (color_key_q),
		.write_enable_s2  (write_enable),
		.write_address_s2 (write_address),
		.write_pixel_s2   (write_pixel),
		.rect_done_s2     (rect_done)
	);

	assign out_valid = valid_s2;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> valid_s1)
		else $error("accepted request not held in the raster stage");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |-> !in_ready)
		else $error("request taken while both stages are full and stalled");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && valid_s2)
		else $error("stalled request dropped");

endmodule

`default_nettype wire

FILE: sim/ckcb_blit_checker.sv
`timescale 1ns / 1ps

module ckcb_blit_checker import ckcb_pkg::*; #(
	parameter int unsigned MAX_RECT_SIDE    = CKCB_MAX_RECT_SIDE,
	parameter int unsigned MAX_DISPLAY_SIDE = CKCB_MAX_DISPLAY_SIDE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [PIXEL_W-1:0]   cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PIXEL_W-1:0]   src_pixel,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 write_enable,
	input  logic [ADDR_W-1:0]    write_address,
	input  logic [PIXEL_W-1:0]   write_pixel,
	input  logic                 rect_done,
	output int unsigned          mismatches,
	output int unsigned          outstanding
);

	localparam int CNT_W = (MAX_RECT_SIDE > 1) ? $clog2(MAX_RECT_SIDE) : 1;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [PIXEL_W-1:0] pixel;
		logic               done;
	} fb_write_t;

	logic signed [COORD_W-1:0] org_x, org_y;
	logic [RSIDE_W-1:0]        rect_w, rect_h;
	logic [DSIDE_W-1:0]        disp_w, disp_h;
	logic [PIXEL_W-1:0]        key;
	logic [CNT_W-1:0]          col, row;
	fb_write_t                 fb_writes_due[$];
	int unsigned               errs = 0;

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Place one source pixel, decide the write and step the raster counters
	function automatic fb_write_t blit_pixel(input logic [PIXEL_W-1:0] p);
		fb_write_t r;
		int        w, h, dw, dh, px, py;
		logic      last_col, last_row, on_screen;
		w  = clamp(int'(rect_w), 1, int'(MAX_RECT_SIDE));
		h  = clamp(int'(rect_h), 1, int'(MAX_RECT_SIDE));
		dw = clamp(int'(disp_w), 0, int'(MAX_DISPLAY_SIDE));
		dh = clamp(int'(disp_h), 0, int'(MAX_DISPLAY_SIDE));
		px = int'(org_x) + int'(col);
		py = int'(org_y) + int'(row);
		last_col  = (int'(col) + 1) >= w;
		last_row  = (int'(row) + 1) >= h;
		on_screen = (px >= 0) && (px < dw) && (py >= 0) && (py < dh);
		r.we    = on_screen && (p != key);
		r.addr  = r.we ? ADDR_W'(py * dw + px) : '0;
		r.pixel = r.we ? p : '0;
		r.done  = last_col && last_row;
		if (last_col) begin
			col = '0;
			row = last_row ? '0 : row + 1'b1;
		end else begin
			col = col + 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fb_write_t due;
		if (!arst_n) begin
			org_x  = DEST_X_RST;
			org_y  = DEST_Y_RST;
			rect_w = RECT_WIDTH_RST;
			rect_h = RECT_HEIGHT_RST;
			disp_w = DISPLAY_WIDTH_RST;
			disp_h = DISPLAY_HEIGHT_RST;
			key    = COLOR_KEY_RST;
			col    = '0;
			row    = '0;
			fb_writes_due.delete();
			outstanding <= 0;
			mismatches  <= errs;
		end else begin
			// retire the oldest expectation before queuing a new one
			if (out_valid && out_ready) begin
				if (fb_writes_due.size() == 0) begin
					$error("result with no request outstanding");
					errs++;
				end else begin
					due = fb_writes_due.pop_front();
					if (write_enable !== due.we) begin
						$error("write_enable: expected %0d, got %0d", due.we, write_enable);
						errs++;
					end
					if (write_address !== due.addr) begin
						$error("write_address: expected %0h, got %0h", due.addr,
							write_address);
						errs++;
					end
					if (write_pixel !== due.pixel) begin
						$error("write_pixel: expected %0h, got %0h", due.pixel, write_pixel);
						errs++;
					end
					if (rect_done !== due.done) begin
						$error("rect_done: expected %0d, got %0d", due.done, rect_done);
						errs++;
					end
				end
			end
			if (cfg_write) begin
				case (ckcb_reg_t'(cfg_index))
					REG_DEST_X:         org_x  = cfg_data[COORD_W-1:0];
					REG_DEST_Y:         org_y  = cfg_data[COORD_W-1:0];
					REG_RECT_WIDTH:     rect_w = cfg_data[RSIDE_W-1:0];
					REG_RECT_HEIGHT:    rect_h = cfg_data[RSIDE_W-1:0];
					REG_DISPLAY_WIDTH:  disp_w = cfg_data[DSIDE_W-1:0];
					REG_DISPLAY_HEIGHT: disp_h = cfg_data[DSIDE_W-1:0];
					REG_COLOR_KEY:      key    = cfg_data;
					default:            ;
				endcase
			end
			if (in_valid && in_ready) begin
				fb_writes_due.push_back(blit_pixel(src_pixel));
			end
			mismatches  <= errs;
			outstanding <= fb_writes_due.size();
		end
	end

endmodule

FILE: sim/color_keyed_clipped_blit_tb.sv
`timescale 1ns / 1ps

module color_keyed_clipped_blit_tb;
	import ckcb_pkg::*;

	// number of defined registers; anything past them is an unused index
	localparam int                   NUM_REGS    = int'(REG_COLOR_KEY) + 1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE   = '1;
	localparam int                   LONG_HOLD   = 300;
	localparam int                   RANDOM_REQS = 1500;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [PIXEL_W-1:0]   cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [PIXEL_W-1:0]   src_pixel = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 write_enable;
	logic [ADDR_W-1:0]    write_address;
	logic [PIXEL_W-1:0]   write_pixel;
	logic                 rect_done;
	int unsigned          mismatches;
	int unsigned          outstanding;

	// register values as last written, and the next set to load
	logic [PIXEL_W-1:0]   shadow   [NUM_REGS];
	logic [PIXEL_W-1:0]   next_val [NUM_REGS];
	bit                   next_sel [NUM_REGS];

	bit                   steady        = 1'b0; // no gaps on either side this phase
	bit                   long_hold_req = 1'b0; // ask the receiver for a long stall
	int                   hold_cnt      = 0;
	int                   random_sent   = 0;

	always #4 clk = ~clk;

	color_keyed_clipped_blit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_pixel     (src_pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_pixel   (write_pixel),
		.rect_done     (rect_done)
	);

	ckcb_blit_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_pixel     (src_pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_pixel   (write_pixel),
		.rect_done     (rect_done),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Idle length: zero with the given odds, else mostly short, a few long
	function automatic int pause_len(input int busy_pct);
		int r;
		if ($urandom_range(0, 99) < busy_pct) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(30, 80);
	endfunction

	function automatic int reg_bits(input int idx);
		case (idx) inside
			REG_DEST_X, REG_DEST_Y:                return COORD_W;
			REG_RECT_WIDTH, REG_RECT_HEIGHT:       return RSIDE_W;
			REG_DISPLAY_WIDTH, REG_DISPLAY_HEIGHT: return DSIDE_W;
			default:                               return PIXEL_W;
		endcase
	endfunction

	function automatic int eff_rect(input logic [PIXEL_W-1:0] v);
		int s;
		s = int'(v[RSIDE_W-1:0]);
		return (s == 0) ? 1 : ((s > int'(CKCB_MAX_RECT_SIDE)) ? int'(CKCB_MAX_RECT_SIDE) : s);
	endfunction

	function automatic int eff_disp(input logic [PIXEL_W-1:0] v);
		int s;
		s = int'(v[DSIDE_W-1:0]);
		return (s > int'(CKCB_MAX_DISPLAY_SIDE)) ? int'(CKCB_MAX_DISPLAY_SIDE) : s;
	endfunction

	function automatic logic [PIXEL_W-1:0] palette_pixel();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			2:       return COLOR_KEY_RST;
			default: return 32'h8000_0001;
		endcase
	endfunction

	// Pixels hit the key often, and its one-bit neighbors too
	function automatic logic [PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0, 1, 2: return shadow[REG_COLOR_KEY];
			3:       return shadow[REG_COLOR_KEY] ^ (32'd1 << $urandom_range(0, 31));
			4:       return palette_pixel();
			default: return $urandom();
		endcase
	endfunction

	function automatic int rect_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(1, 6);
		if (r < 78) return $urandom_range(7, 40);
		if (r < 85) return 0;
		if (r < 92) return 256;
		return $urandom_range(257, 511);
	endfunction

	function automatic int disp_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return $urandom_range(1, 24);
		if (r < 65) return $urandom_range(25, 2048);
		if (r < 73) return 0;
		if (r < 82) return 2048;
		if (r < 90) return $urandom_range(2049, 4095);
		return $urandom_range(1, 4);
	endfunction

	// Place the rectangle mostly around the display edges so clipping bites
	function automatic int dest_pick(input int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, span + 16) - 12;
		if (r < 78) return -2048;
		if (r < 86) return 2047;
		return $urandom_range(0, 4095);
	endfunction

	// Write one register; fill the bits above its width with junk
	task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [PIXEL_W-1:0] val);
		int                 bits;
		logic [PIXEL_W-1:0] mask;
		logic [PIXEL_W-1:0] junk;
		bits = reg_bits(idx);
		mask = (bits < PIXEL_W) ? ((32'd1 << bits) - 1) : '1;
		junk = (bits < PIXEL_W) ? ($urandom() << bits) : '0;
		if (idx < NUM_REGS) begin
			shadow[idx] = val & mask;
		end
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= (val & mask) | junk;
		@(posedge clk);
	endtask

	// Load the selected registers back to back, now and then poke the unused index
	task automatic write_regs();
		for (int i = 0; i < NUM_REGS; i++) begin
			if (next_sel[i]) begin
				set_reg(REG_IDX_W'(i), next_val[i]);
			end
		end
		if ($urandom_range(0, 7) == 0) begin
			set_reg(REG_SPARE, $urandom());
		end
		cfg_write <= 1'b0;
	endtask

	task automatic load_regs(input int dx, input int dy, input int rw, input int rh,
		input int dw, input int dh, input logic [PIXEL_W-1:0] ck);
		next_val[REG_DEST_X]         = dx;
		next_val[REG_DEST_Y]         = dy;
		next_val[REG_RECT_WIDTH]     = rw;
		next_val[REG_RECT_HEIGHT]    = rh;
		next_val[REG_DISPLAY_WIDTH]  = dw;
		next_val[REG_DISPLAY_HEIGHT] = dh;
		next_val[REG_COLOR_KEY]      = ck;
		foreach (next_sel[i]) begin
			next_sel[i] = 1'b1;
		end
		write_regs();
	endtask

	// Offer one pixel, hold it until taken, then maybe idle
	task automatic send_pixel(input logic [PIXEL_W-1:0] p);
		int gap;
		in_valid  <= 1'b1;
		src_pixel <= p;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		gap = steady ? 0 : pause_len(55);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every predicted write to come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	// One random phase: maybe new settings, then mostly whole rectangles
	task automatic random_phase(input bit pressure);
		int n, wh, dw, dh;
		if ($urandom_range(0, 4) != 0) begin
			foreach (next_sel[i]) begin
				next_sel[i] = ($urandom_range(0, 9) < 7);
			end
			next_val[REG_RECT_WIDTH]     = rect_pick();
			next_val[REG_RECT_HEIGHT]    = rect_pick();
			next_val[REG_DISPLAY_WIDTH]  = disp_pick();
			next_val[REG_DISPLAY_HEIGHT] = disp_pick();
			dw = eff_disp(next_sel[REG_DISPLAY_WIDTH] ? next_val[REG_DISPLAY_WIDTH] :
				shadow[REG_DISPLAY_WIDTH]);
			dh = eff_disp(next_sel[REG_DISPLAY_HEIGHT] ? next_val[REG_DISPLAY_HEIGHT] :
				shadow[REG_DISPLAY_HEIGHT]);
			next_val[REG_DEST_X]    = dest_pick(dw);
			next_val[REG_DEST_Y]    = dest_pick(dh);
			next_val[REG_COLOR_KEY] = ($urandom_range(0, 1) == 0) ? palette_pixel() : $urandom();
			write_regs();
		end
		steady = ($urandom_range(0, 3) == 0);
		wh = eff_rect(shadow[REG_RECT_WIDTH]) * eff_rect(shadow[REG_RECT_HEIGHT]);
		if (wh <= 300 && $urandom_range(0, 4) != 0) begin
			n = wh * $urandom_range(1, 3);
		end else begin
			n = $urandom_range(1, 60);
		end
		if (pressure) begin
			// keep offering back to back while the receiver sits on its hands
			steady        = 1'b1;
			long_hold_req = 1'b1;
			if (n < 40) begin
				n = 40;
			end
		end
		repeat (n) send_pixel(pick_pixel());
		drain();
		random_sent += n;
	endtask

	// Receiver: random stalls, steady phases, and one long hold on request
	always @(posedge clk) begin
		int stall_len;
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_cnt      = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			stall_len = steady ? 0 : pause_len(75);
			out_ready <= (stall_len == 0);
			if (stall_len > 0) begin
				hold_cnt = stall_len - 1;
			end
		end
	end

	initial begin
		shadow[REG_DEST_X]         = DEST_X_RST;
		shadow[REG_DEST_Y]         = DEST_Y_RST;
		shadow[REG_RECT_WIDTH]     = RECT_WIDTH_RST;
		shadow[REG_RECT_HEIGHT]    = RECT_HEIGHT_RST;
		shadow[REG_DISPLAY_WIDTH]  = DISPLAY_WIDTH_RST;
		shadow[REG_DISPLAY_HEIGHT] = DISPLAY_HEIGHT_RST;
		shadow[REG_COLOR_KEY]      = COLOR_KEY_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the default key, its neighbor and the all-zero/all-one pixels
		send_pixel(COLOR_KEY_RST);
		send_pixel('0);
		send_pixel('1);
		send_pixel(COLOR_KEY_RST ^ 32'h1);
		drain();

		// Shrink to a zero-size rectangle mid-row: the counter past the end wraps,
		// every pixel ends a rectangle; oversize width, zero height, all clipped
		load_regs(2047, -2048, 0, 0, 4095, 0, '0);
		send_pixel('0);
		send_pixel('1);
		send_pixel($urandom());
		drain();

		// Bottom-right corner of the largest display: highest address, then
		// the strict edge tests, then the key on a visible pixel
		load_regs(2047, 2047, 2, 2, 2048, 2048, '1);
		send_pixel(32'h1234_5678);
		send_pixel(32'hFFFF_FFFE);
		send_pixel('0);
		send_pixel(32'h1);
		send_pixel('1);
		drain();

		// One-pixel display with the rectangle hanging off its top-left
		load_regs(-1, -1, 3, 3, 1, 1, COLOR_KEY_RST);
		repeat (9) send_pixel($urandom());
		drain();

		// Random phases; the first and a few later ones back up the block
		random_phase(1'b1);
		while (random_sent < RANDOM_REQS) begin
			random_phase($urandom_range(0, 11) == 0);
		end

		steady = 1'b0;
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
